/* sv/bxt_pkg.sv */
// Shared types and constants for the binary XOR trie multiset.
// Used by binary_xor_trie_multiset; depends on nothing else.
package bxt_pkg;

  localparam int KeyBits   = 32;
  localparam int NodeCount = 4096;
  localparam int MaxItems  = 65535;
  localparam int NodeAw    = $clog2(NodeCount);
  localparam int CntW      = 16;
  localparam int LvlW      = $clog2(KeyBits);
  localparam int NfnW      = NodeAw + 1;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TAKE_MIN = 2'd2,
    OP_TAKE_MAX = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic [KeyBits-1:0]  key;
  } in_t;

  typedef struct packed {
    logic [KeyBits-1:0]  xor_value;
    status_e             status;
  } out_t;

  // One trie node: both child links and the pass-through count.
  typedef struct packed {
    logic [NodeAw-1:0]   c0;
    logic [NodeAw-1:0]   c1;
    logic [CntW-1:0]     cnt;
  } ent_t;

  localparam int EntW = $bits(ent_t);

  function automatic logic [NodeAw-1:0] link_of(ent_t e, logic b);
    return b ? e.c1 : e.c0;
  endfunction

  function automatic ent_t set_link(ent_t e, logic b, logic [NodeAw-1:0] c);
    ent_t r;
    r = e;
    if (b) begin
      r.c1 = c;
    end else begin
      r.c0 = c;
    end
    return r;
  endfunction

endpackage

/* sv/bxt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bxt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/binary_xor_trie_multiset.sv */
// Top level of the binary XOR trie multiset: sequencer around one node RAM.
// Depends on bxt_pkg and bxt_ram.
//
//  channel | direction | handshake            | payload
//  input   | in        | in_valid_i/in_stall_o | in_data_i  (bxt_pkg::in_t)
//  output  | out       | out_valid_o/out_stall_i | out_data_o (bxt_pkg::out_t)
//
// The check walk passes a link state and a data state per existing trie level
// (a second data state where a take probes the second child) and a link state
// where an insert path leaves the trie. The update walk passes a link state
// and a data state per existing level and a link state per new node. A new
// input waits until the last item is answered; the single read port sets pace.
// Failed operations answer after the check walk or at once.
// Reset leaves an empty set; nodes are written when allocated, so no sweep.
// A stalled result waits in the output register while the next item is taken.
module binary_xor_trie_multiset (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bxt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bxt_pkg::out_t  out_data_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHK_LINK = 3'd1;
  localparam logic [2:0] S_CHK_DATA = 3'd2;
  localparam logic [2:0] S_CHK_END  = 3'd3;
  localparam logic [2:0] S_UPD_LINK = 3'd4;
  localparam logic [2:0] S_UPD_DATA = 3'd5;
  localparam logic [2:0] S_UPD_LAST = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  localparam logic [bxt_pkg::LvlW-1:0] TopLvl = bxt_pkg::LvlW'(bxt_pkg::KeyBits - 1);

  logic [2:0]                       state_q, state_d;
  bxt_pkg::op_e                     op_q, op_d;
  logic [bxt_pkg::KeyBits-1:0]      key_q, key_d;
  logic [bxt_pkg::KeyBits-1:0]      matched_q, matched_d;
  logic [bxt_pkg::LvlW-1:0]         lvl_q, lvl_d;
  bxt_pkg::ent_t                    cur_q, cur_d;
  logic [bxt_pkg::NodeAw-1:0]       cur_addr_q, cur_addr_d;
  logic                             cur_root_q, cur_root_d;
  logic [bxt_pkg::NodeAw-1:0]       child_q, child_d;
  logic                             alt_q, alt_d;
  logic [bxt_pkg::LvlW:0]           need_q, need_d;
  bxt_pkg::status_e                 status_q, status_d;
  logic [bxt_pkg::NodeAw-1:0]       root_c0_q, root_c0_d;
  logic [bxt_pkg::NodeAw-1:0]       root_c1_q, root_c1_d;
  logic [bxt_pkg::NfnW-1:0]         nfn_q, nfn_d;
  logic [bxt_pkg::CntW-1:0]         total_q, total_d;
  logic                             out_valid_q, out_valid_d;
  bxt_pkg::out_t                    out_q, out_d;

  logic                             ram_we;
  logic [bxt_pkg::NodeAw-1:0]       ram_waddr, ram_raddr;
  bxt_pkg::ent_t                    ram_wdata, ram_rdata;
  logic [bxt_pkg::EntW-1:0]         ram_rbits;

  logic                             is_take, pref, pbit;
  logic [bxt_pkg::NodeAw-1:0]       lnk_p, lnk_o, lnk_u;
  bxt_pkg::ent_t                    root_ent, newp;
  logic [bxt_pkg::NfnW-1:0]         room;

  bxt_ram #(
    .Width (bxt_pkg::EntW),
    .Depth (bxt_pkg::NodeCount)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  assign ram_rdata = bxt_pkg::ent_t'(ram_rbits);

  assign is_take  = (op_q == bxt_pkg::OP_TAKE_MIN) || (op_q == bxt_pkg::OP_TAKE_MAX);
  assign pref     = key_q[lvl_q] ^ (op_q == bxt_pkg::OP_TAKE_MAX);
  assign pbit     = is_take ? matched_q[lvl_q] : key_q[lvl_q];
  assign lnk_p    = bxt_pkg::link_of(cur_q, pref);
  assign lnk_o    = bxt_pkg::link_of(cur_q, ~pref);
  assign lnk_u    = bxt_pkg::link_of(cur_q, pbit);
  assign root_ent = '{c0: root_c0_q, c1: root_c1_q, cnt: '0};
  assign newp     = bxt_pkg::set_link(cur_q, pbit, nfn_q[bxt_pkg::NodeAw-1:0]);
  assign room     = bxt_pkg::NfnW'(bxt_pkg::NodeCount) - nfn_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    matched_d   = matched_q;
    lvl_d       = lvl_q;
    cur_d       = cur_q;
    cur_addr_d  = cur_addr_q;
    cur_root_d  = cur_root_q;
    child_d     = child_q;
    alt_d       = alt_q;
    need_d      = need_q;
    status_d    = status_q;
    root_c0_d   = root_c0_q;
    root_c1_d   = root_c1_q;
    nfn_d       = nfn_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_addr_q;
    ram_wdata   = cur_q;
    ram_raddr   = lnk_p;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = in_data_i.op;
          key_d      = in_data_i.key;
          matched_d  = '0;
          lvl_d      = TopLvl;
          cur_d      = root_ent;
          cur_addr_d = '0;
          cur_root_d = 1'b1;
          alt_d      = 1'b0;
          need_d     = '0;
          status_d   = bxt_pkg::ST_OK;
          if (in_data_i.op == bxt_pkg::OP_INSERT) begin
            if (total_q >= bxt_pkg::CntW'(bxt_pkg::MaxItems)) begin
              status_d = bxt_pkg::ST_FULL;
              state_d  = S_RESP;
            end else begin
              state_d = S_CHK_LINK;
            end
          end else if (total_q == '0) begin
            status_d = bxt_pkg::ST_EMPTY;
            state_d  = S_RESP;
          end else begin
            state_d = S_CHK_LINK;
          end
        end
      end

      S_CHK_LINK: begin
        alt_d = 1'b0;
        if (is_take) begin
          if (lnk_p != '0) begin
            ram_raddr = lnk_p;
            state_d   = S_CHK_DATA;
          end else if (lnk_o != '0) begin
            ram_raddr = lnk_o;
            alt_d     = 1'b1;
            state_d   = S_CHK_DATA;
          end else begin
            status_d = bxt_pkg::ST_EMPTY;
            state_d  = S_RESP;
          end
        end else begin
          ram_raddr = bxt_pkg::link_of(cur_q, key_q[lvl_q]);
          if (ram_raddr != '0) begin
            state_d = S_CHK_DATA;
          end else if (op_q == bxt_pkg::OP_INSERT) begin
            // The rest of the path is new; every remaining level needs a node.
            need_d  = {1'b0, lvl_q} + 1'b1;
            state_d = S_CHK_END;
          end else begin
            status_d = bxt_pkg::ST_MISSING;
            state_d  = S_RESP;
          end
        end
      end

      S_CHK_DATA: begin
        if (op_q != bxt_pkg::OP_INSERT && ram_rdata.cnt == '0) begin
          if (op_q == bxt_pkg::OP_DELETE) begin
            status_d = bxt_pkg::ST_MISSING;
            state_d  = S_RESP;
          end else if (!alt_q && lnk_o != '0) begin
            ram_raddr = lnk_o;
            alt_d     = 1'b1;
          end else begin
            status_d = bxt_pkg::ST_EMPTY;
            state_d  = S_RESP;
          end
        end else begin
          if (is_take) begin
            matched_d[lvl_q] = pref ^ alt_q;
          end
          cur_d      = ram_rdata;
          cur_root_d = 1'b0;
          if (lvl_q == '0) begin
            state_d = S_CHK_END;
          end else begin
            lvl_d   = lvl_q - 1'b1;
            state_d = S_CHK_LINK;
          end
        end
      end

      S_CHK_END: begin
        cur_d      = root_ent;
        cur_addr_d = '0;
        cur_root_d = 1'b1;
        lvl_d      = TopLvl;
        if (bxt_pkg::NfnW'(need_q) > room) begin
          status_d = bxt_pkg::ST_FULL;
          state_d  = S_RESP;
        end else begin
          state_d = S_UPD_LINK;
        end
      end

      S_UPD_LINK: begin
        // Write back the parent, linking a fresh node where the path ends.
        if (lnk_u == '0) begin
          ram_wdata = newp;
          cur_d     = '{c0: '0, c1: '0, cnt: bxt_pkg::CntW'(1)};
          cur_addr_d = nfn_q[bxt_pkg::NodeAw-1:0];
          nfn_d     = nfn_q + 1'b1;
          if (lvl_q == '0) begin
            state_d = S_UPD_LAST;
          end else begin
            lvl_d = lvl_q - 1'b1;
          end
        end else begin
          ram_wdata = cur_q;
          ram_raddr = lnk_u;
          child_d   = lnk_u;
          state_d   = S_UPD_DATA;
        end
        cur_root_d = 1'b0;
        if (cur_root_q) begin
          root_c0_d = ram_wdata.c0;
          root_c1_d = ram_wdata.c1;
        end else begin
          ram_we = 1'b1;
        end
      end

      S_UPD_DATA: begin
        cur_d = ram_rdata;
        if (op_q == bxt_pkg::OP_INSERT) begin
          cur_d.cnt = ram_rdata.cnt + 1'b1;
        end else begin
          cur_d.cnt = ram_rdata.cnt - 1'b1;
        end
        cur_addr_d = child_q;
        if (lvl_q == '0) begin
          state_d = S_UPD_LAST;
        end else begin
          lvl_d   = lvl_q - 1'b1;
          state_d = S_UPD_LINK;
        end
      end

      S_UPD_LAST: begin
        ram_we    = 1'b1;
        ram_wdata = cur_q;
        if (op_q == bxt_pkg::OP_INSERT) begin
          total_d = total_q + 1'b1;
        end else begin
          total_d = total_q - 1'b1;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.status    = status_q;
          out_d.xor_value = (is_take && status_q == bxt_pkg::ST_OK) ?
                            (key_q ^ matched_q) : '0;
          state_d         = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      root_c0_q   <= '0;
      root_c1_q   <= '0;
      nfn_q       <= bxt_pkg::NfnW'(1);
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_c0_q   <= root_c0_d;
      root_c1_q   <= root_c1_d;
      nfn_q       <= nfn_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    matched_q  <= matched_d;
    lvl_q      <= lvl_d;
    cur_q      <= cur_d;
    cur_addr_q <= cur_addr_d;
    cur_root_q <= cur_root_d;
    child_q    <= child_d;
    alt_q      <= alt_d;
    need_q     <= need_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

endmodule
